FILE: rtl/fchs_pkg.sv
// ----------------------------------------------------------------------------
// fchs_pkg
// Shared types and constants for the fast-charge handshake sequencer.
// ----------------------------------------------------------------------------
package fchs_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_VBUS_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_START_WAIT     = 3'd1;
	localparam logic [2:0] REG_DISC_WAIT      = 3'd2;
	localparam logic [2:0] REG_CONFIRM_WINDOW = 3'd3;
	localparam logic [2:0] REG_OK_WAIT        = 3'd4;
	localparam logic [2:0] REG_SETTLE         = 3'd5;

	// data-line control and status codes
	localparam logic [7:0] DM_SHORT    = 8'h48;
	localparam logic [7:0] DM_RELEASE  = 8'h84;
	localparam logic [7:0] DM_REQ_HV   = 8'h64;
	localparam logic [7:0] DM_OFF      = 8'h00;
	localparam logic [7:0] ST_READY    = 8'h05;
	localparam logic [7:0] ST_CONFIRM  = 8'h04;

	// input regulation settings
	localparam logic [7:0] VIN_FALLBACK = 8'd42;
	localparam logic [7:0] VIN_RAISED   = 8'd80;

	// outcome codes
	localparam logic [1:0] OUT_PENDING = 2'd0;
	localparam logic [1:0] OUT_FAST    = 2'd1;
	localparam logic [1:0] OUT_FAILED  = 2'd2;

	// reset values of the configuration registers
	localparam logic [14:0] RST_VBUS_THRESHOLD = 15'd8300;
	localparam logic [7:0]  RST_START_WAIT     = 8'd20;
	localparam logic [7:0]  RST_DISC_WAIT      = 8'd10;
	localparam logic [7:0]  RST_CONFIRM_WINDOW = 8'd200;
	localparam logic [7:0]  RST_OK_WAIT        = 8'd100;
	localparam logic [7:0]  RST_SETTLE         = 8'd10;

	// status sampling period in the confirm window
	localparam logic [7:0] CONFIRM_PERIOD = 8'd10;

	typedef struct packed {
		logic       dm_write;
		logic [7:0] dm_value;
		logic       vin_write;
		logic [7:0] vin_value;
		logic       gpo_set;
		logic       charge_start;
		logic       charge_pause;
		logic       charge_resume;
		logic       fast_charge;
		logic       proceed;
		logic [1:0] outcome;
		logic [3:0] phase;
	} result_t;

endpackage

FILE: rtl/fast_charge_handshake_fsm_unit.sv
// ----------------------------------------------------------------------------
// fast_charge_handshake_fsm_unit
// Tick-driven sink-side fast-charge handshake sequencer with a skid output.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the skid entry is empty; each result
//   beat is one combinational pass into the result register or the skid entry.
// A skid entry behind the result register keeps the input open for one more
//   beat while the downstream side stalls.
// Reset (arst_n low, asynchronous): idle phase, zero countdown, outcome
//   pending, both result entries empty, registers at their default values.
module fast_charge_handshake_fsm_unit #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data,
	// input beat
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  dm_status,
	input  logic [9:0]  vbus_code,
	// result beat
	output logic        out_valid,
	input  logic        out_ready,
	output logic        dm_write,
	output logic [7:0]  dm_value,
	output logic        vin_write,
	output logic [7:0]  vin_value,
	output logic        gpo_set,
	output logic        charge_start,
	output logic        charge_pause,
	output logic        charge_resume,
	output logic        fast_charge,
	output logic        proceed,
	output logic [1:0]  outcome,
	output logic [3:0]  phase
);

	// phase codes
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_START   = 4'd1;
	localparam logic [3:0] PH_DISC    = 4'd2;
	localparam logic [3:0] PH_CONFIRM = 4'd3;
	localparam logic [3:0] PH_OKWAIT  = 4'd4;
	localparam logic [3:0] PH_VINSET  = 4'd5;
	localparam logic [3:0] PH_REQSET  = 4'd6;
	localparam logic [3:0] PH_RETRY   = 4'd7;
	localparam logic [3:0] PH_FAIL    = 4'd8;
	localparam logic [3:0] PH_OVER    = 4'd9;

	// configuration registers
	logic [14:0] vbus_threshold_q;
	logic [7:0]  start_wait_q;
	logic [7:0]  disc_wait_q;
	logic [7:0]  confirm_window_q;
	logic [7:0]  ok_wait_q;
	logic [7:0]  settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbus_threshold_q <= fchs_pkg::RST_VBUS_THRESHOLD;
			start_wait_q     <= fchs_pkg::RST_START_WAIT;
			disc_wait_q      <= fchs_pkg::RST_DISC_WAIT;
			confirm_window_q <= fchs_pkg::RST_CONFIRM_WINDOW;
			ok_wait_q        <= fchs_pkg::RST_OK_WAIT;
			settle_q         <= fchs_pkg::RST_SETTLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fchs_pkg::REG_VBUS_THRESHOLD: vbus_threshold_q <= cfg_data;
				fchs_pkg::REG_START_WAIT:     start_wait_q     <= cfg_data[7:0];
				fchs_pkg::REG_DISC_WAIT:      disc_wait_q      <= cfg_data[7:0];
				fchs_pkg::REG_CONFIRM_WINDOW: confirm_window_q <= cfg_data[7:0];
				fchs_pkg::REG_OK_WAIT:        ok_wait_q        <= cfg_data[7:0];
				fchs_pkg::REG_SETTLE:         settle_q         <= cfg_data[7:0];
				default: ;  // unmapped index, ignored
			endcase
		end
	end

	// sequencer state
	logic [3:0]             phase_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [1:0]             outcome_q;

	logic [3:0]             phase_d;
	logic [COUNT_WIDTH-1:0] cnt_d;
	logic [1:0]             outcome_d;
	fchs_pkg::result_t      res;

	// output staging: result register plus one skid entry
	fchs_pkg::result_t res_q;
	fchs_pkg::result_t skid_q;
	logic              res_valid_q;
	logic              skid_valid_q;

	logic in_take;
	logic out_take;

	assign in_ready = !skid_valid_q;
	assign in_take  = in_valid && in_ready;
	assign out_take = res_valid_q && out_ready;

	// bus millivolts = (code + 1) * 25, as shifts and adds
	logic [10:0] code_p1;
	logic [14:0] vbus_mv;
	assign code_p1 = {1'b0, vbus_code} + 11'd1;
	assign vbus_mv = {code_p1, 4'b0} + {1'b0, code_p1, 3'b0} + {4'b0, code_p1};

	logic low_mv;
	logic high_mv;
	assign low_mv  = vbus_mv < vbus_threshold_q;
	assign high_mv = vbus_mv > vbus_threshold_q;

	// countdown decrement and its residue mod 10; loads never exceed 8 bits,
	// so the low byte carries the whole value
	logic                   cnt_zero;
	logic [COUNT_WIDTH-1:0] cnt_dec;
	logic [15:0]            div_prod;
	logic [4:0]             div_quo;
	logic [7:0]             dec_mod;
	logic                   confirm_hit;

	assign cnt_zero = (cnt_q == '0);
	assign cnt_dec  = cnt_zero ? cnt_q : cnt_q - COUNT_WIDTH'(1);
	// x / 10 == (x * 205) >> 11 for x below 1029
	assign div_prod = 16'(cnt_dec[7:0]) * 16'd205;
	assign div_quo  = div_prod[15:11];
	assign dec_mod  = cnt_dec[7:0] - 8'(div_quo * fchs_pkg::CONFIRM_PERIOD);
	assign confirm_hit = (dec_mod == 8'd0) && (dm_status == fchs_pkg::ST_CONFIRM);

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		outcome_d = outcome_q;
		res       = '0;
		res.proceed = 1'b1;

		if (!operation) begin
			// start: fallback line and input limit, slow charge, clear state
			res.gpo_set      = 1'b1;
			res.dm_write     = 1'b1;
			res.dm_value     = fchs_pkg::DM_OFF;
			res.vin_write    = 1'b1;
			res.vin_value    = fchs_pkg::VIN_FALLBACK;
			res.charge_start = 1'b1;
			res.proceed      = 1'b0;
			phase_d          = PH_IDLE;
			cnt_d            = '0;
			outcome_d        = fchs_pkg::OUT_PENDING;
		end else if (outcome_q == fchs_pkg::OUT_FAILED) begin
			res.proceed = 1'b0;
		end else if (outcome_q == fchs_pkg::OUT_FAST) begin
			res.proceed = 1'b1;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					res.dm_write     = 1'b1;
					res.dm_value     = fchs_pkg::DM_SHORT;
					res.charge_pause = 1'b1;
					phase_d          = PH_START;
					cnt_d            = COUNT_WIDTH'(start_wait_q);
				end
				PH_START, PH_DISC: begin
					if (!cnt_zero) begin
						cnt_d = cnt_dec;
					end else if (dm_status == fchs_pkg::ST_READY) begin
						res.dm_write = 1'b1;
						if (phase_q == PH_START) begin
							res.dm_value = fchs_pkg::DM_RELEASE;
							phase_d      = PH_DISC;
							cnt_d        = COUNT_WIDTH'(disc_wait_q);
						end else begin
							res.dm_value = fchs_pkg::DM_SHORT;
							phase_d      = PH_CONFIRM;
							cnt_d        = COUNT_WIDTH'(confirm_window_q);
						end
					end else begin
						phase_d = PH_FAIL;
					end
				end
				PH_CONFIRM: begin
					// the fail test looks at the countdown after any reload
					if (confirm_hit) begin
						res.dm_write = 1'b1;
						res.dm_value = fchs_pkg::DM_SHORT;
						cnt_d        = COUNT_WIDTH'(ok_wait_q);
						phase_d      = (ok_wait_q == 8'd0) ? PH_FAIL : PH_OKWAIT;
					end else begin
						cnt_d = cnt_dec;
						if (cnt_dec == '0) begin
							phase_d = PH_FAIL;
						end
					end
				end
				PH_OKWAIT: begin
					if (!cnt_zero) begin
						cnt_d = cnt_dec;
					end else begin
						res.vin_write = 1'b1;
						res.vin_value = fchs_pkg::VIN_RAISED;
						phase_d       = PH_VINSET;
						cnt_d         = COUNT_WIDTH'(settle_q);
					end
				end
				PH_VINSET: begin
					if (!cnt_zero) begin
						cnt_d = cnt_dec;
					end else begin
						res.dm_write = 1'b1;
						res.dm_value = fchs_pkg::DM_REQ_HV;
						phase_d      = PH_REQSET;
						cnt_d        = COUNT_WIDTH'(settle_q);
					end
				end
				PH_REQSET: begin
					if (!cnt_zero) begin
						cnt_d = cnt_dec;
					end else if (low_mv) begin
						phase_d = PH_RETRY;
						cnt_d   = COUNT_WIDTH'(settle_q);
					end else begin
						res.charge_resume = 1'b1;
						res.fast_charge   = 1'b1;
						outcome_d         = fchs_pkg::OUT_FAST;
						phase_d           = PH_OVER;
					end
				end
				PH_RETRY: begin
					// retry must clear the threshold strictly
					if (!cnt_zero) begin
						cnt_d = cnt_dec;
					end else if (high_mv) begin
						res.charge_resume = 1'b1;
						res.fast_charge   = 1'b1;
						outcome_d         = fchs_pkg::OUT_FAST;
						phase_d           = PH_OVER;
					end else begin
						phase_d = PH_FAIL;
					end
				end
				PH_FAIL: begin
					res.charge_resume = 1'b1;
					res.gpo_set       = 1'b1;
					res.dm_write      = 1'b1;
					res.dm_value      = fchs_pkg::DM_OFF;
					res.vin_write     = 1'b1;
					res.vin_value     = fchs_pkg::VIN_FALLBACK;
					res.proceed       = 1'b0;
					outcome_d         = fchs_pkg::OUT_FAILED;
				end
				default: begin
					// over, and codes that never occur
					res.proceed = 1'b1;
				end
			endcase
		end

		res.outcome = outcome_d;
		res.phase   = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			outcome_q <= fchs_pkg::OUT_PENDING;
		end else if (in_take) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			outcome_q <= outcome_d;
		end
	end

	// result register and skid entry control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid_q || out_take) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= in_take;
			end
		end else if (in_take) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (!res_valid_q || out_take) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (in_take) begin
				res_q <= res;
			end
		end else if (in_take) begin
			skid_q <= res;
		end
	end

	assign out_valid     = res_valid_q;
	assign dm_write      = res_q.dm_write;
	assign dm_value      = res_q.dm_value;
	assign vin_write     = res_q.vin_write;
	assign vin_value     = res_q.vin_value;
	assign gpo_set       = res_q.gpo_set;
	assign charge_start  = res_q.charge_start;
	assign charge_pause  = res_q.charge_pause;
	assign charge_resume = res_q.charge_resume;
	assign fast_charge   = res_q.fast_charge;
	assign proceed       = res_q.proceed;
	assign outcome       = res_q.outcome;
	assign phase         = res_q.phase;

endmodule

FILE: rtl/fchs_checker.sv
// ----------------------------------------------------------------------------
// fchs_checker
// Port-level checks on the fast-charge handshake sequencer, bound to the top.
// ----------------------------------------------------------------------------
module fchs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       dm_write,
	input logic [7:0] dm_value,
	input logic [7:0] vin_value,
	input logic       gpo_set,
	input logic       charge_start,
	input logic       charge_resume,
	input logic       fast_charge,
	input logic       proceed,
	input logic [1:0] outcome,
	input logic [3:0] phase
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(outcome))
		else $error("result beat changed while stalled");

	a_fail_no_proceed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == fchs_pkg::OUT_FAILED |-> !proceed)
		else $error("proceed raised after failure");

	a_fast_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fast_charge |-> outcome == fchs_pkg::OUT_FAST && proceed && charge_resume)
		else $error("fast charge beat inconsistent");

	a_start_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && charge_start |-> phase == 4'd0 && outcome == fchs_pkg::OUT_PENDING
			&& gpo_set && vin_value == fchs_pkg::VIN_FALLBACK && !proceed)
		else $error("start beat inconsistent");

	a_dm_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dm_write |-> dm_value == 8'd0)
		else $error("line control value without write");

endmodule

bind fast_charge_handshake_fsm_unit fchs_checker u_fchs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.dm_write     (dm_write),
	.dm_value     (dm_value),
	.vin_value    (vin_value),
	.gpo_set      (gpo_set),
	.charge_start (charge_start),
	.charge_resume(charge_resume),
	.fast_charge  (fast_charge),
	.proceed      (proceed),
	.outcome      (outcome),
	.phase        (phase)
);

FILE: bench/fast_charge_handshake_fsm_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_charge_handshake_fsm_unit_tb
// Self-checking bench for the tick-driven fast-charge handshake sequencer.
// A behavioral copy of the sequencer predicts every result beat as input beats
// are taken. A separate process compares each result beat field by field.
// Directed handshakes come first. Guided random traffic then runs under several
// register settings, with random gaps on both sides and a long output stall.
// ----------------------------------------------------------------------------
module fast_charge_handshake_fsm_unit_tb;

	localparam int CNT_W        = 8;
	localparam int STALL_CYCLES = 150;

	// operation field encoding
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// handshake phases as reported on the phase port
	typedef enum logic [3:0] {
		HS_IDLE         = 4'd0,
		HS_START_WAIT   = 4'd1,
		HS_DISC_WAIT    = 4'd2,
		HS_CONFIRM      = 4'd3,
		HS_OK_WAIT      = 4'd4,
		HS_VIN_SETTLE   = 4'd5,
		HS_REQ_SETTLE   = 4'd6,
		HS_RETRY_SETTLE = 4'd7,
		HS_FAILING      = 4'd8,
		HS_DONE         = 4'd9
	} hs_phase_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [14:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [7:0]  dm_status;
	logic [9:0]  vbus_code;
	logic        out_valid;
	logic        out_ready;
	logic        dm_write;
	logic [7:0]  dm_value;
	logic        vin_write;
	logic [7:0]  vin_value;
	logic        gpo_set;
	logic        charge_start;
	logic        charge_pause;
	logic        charge_resume;
	logic        fast_charge;
	logic        proceed;
	logic [1:0]  outcome;
	logic [3:0]  phase;

	// shadow of the sequencer state and its registers
	hs_phase_t        hs_phase;
	logic [CNT_W-1:0] hs_count;
	logic [1:0]       hs_outcome;
	logic [14:0]      thr_mv;
	logic [7:0]       wait_start;
	logic [7:0]       wait_disc;
	logic [7:0]       win_confirm;
	logic [7:0]       wait_ok;
	logic [7:0]       wait_settle;

	fchs_pkg::result_t expected_results[$];
	int                err_count;

	// idle control: the sender/receiver gap at random unless switched off
	bit in_gaps_on;
	bit out_gaps_on;
	bit stall_req;

	fast_charge_handshake_fsm_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.dm_status     (dm_status),
		.vbus_code     (vbus_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.dm_write      (dm_write),
		.dm_value      (dm_value),
		.vin_write     (vin_write),
		.vin_value     (vin_value),
		.gpo_set       (gpo_set),
		.charge_start  (charge_start),
		.charge_pause  (charge_pause),
		.charge_resume (charge_resume),
		.fast_charge   (fast_charge),
		.proceed       (proceed),
		.outcome       (outcome),
		.phase         (phase)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequencer prediction
	// ------------------------------------------------------------------

	// fallback: general output bit, lines off, input regulation back to 42
	function automatic fchs_pkg::result_t with_fallback(input fchs_pkg::result_t r);
		r.gpo_set   = 1'b1;
		r.dm_write  = 1'b1;
		r.dm_value  = fchs_pkg::DM_OFF;
		r.vin_write = 1'b1;
		r.vin_value = fchs_pkg::VIN_FALLBACK;
		return r;
	endfunction

	function automatic fchs_pkg::result_t with_fast_charge(input fchs_pkg::result_t r);
		r.charge_resume = 1'b1;
		r.fast_charge   = 1'b1;
		hs_outcome      = fchs_pkg::OUT_FAST;
		hs_phase        = HS_DONE;
		return r;
	endfunction

	// one input beat in, one result beat out; advances the shadow state
	function automatic fchs_pkg::result_t predict_beat(input logic op,
			input logic [7:0] st, input logic [9:0] code);
		fchs_pkg::result_t r;
		int unsigned       mv;
		r         = '0;
		r.proceed = 1'b1;
		mv        = (int'(code) + 1) * 25;

		if (op == OP_START) begin
			r              = with_fallback(r);
			r.charge_start = 1'b1;
			r.proceed      = 1'b0;
			hs_phase       = HS_IDLE;
			hs_count       = '0;
			hs_outcome     = fchs_pkg::OUT_PENDING;
		end else if (hs_outcome == fchs_pkg::OUT_FAILED) begin
			r.proceed = 1'b0;
		end else if (hs_outcome == fchs_pkg::OUT_FAST) begin
			r.proceed = 1'b1;
		end else begin
			case (hs_phase)
				HS_IDLE: begin
					r.dm_write     = 1'b1;
					r.dm_value     = fchs_pkg::DM_SHORT;
					r.charge_pause = 1'b1;
					hs_phase       = HS_START_WAIT;
					hs_count       = wait_start;
				end
				HS_START_WAIT, HS_DISC_WAIT: begin
					if (hs_count != 0) begin
						hs_count--;
					end else if (st == fchs_pkg::ST_READY) begin
						r.dm_write = 1'b1;
						if (hs_phase == HS_START_WAIT) begin
							r.dm_value = fchs_pkg::DM_RELEASE;
							hs_phase   = HS_DISC_WAIT;
							hs_count   = wait_disc;
						end else begin
							r.dm_value = fchs_pkg::DM_SHORT;
							hs_phase   = HS_CONFIRM;
							hs_count   = win_confirm;
						end
					end else begin
						hs_phase = HS_FAILING;
					end
				end
				HS_CONFIRM: begin
					// status only looked at on multiples of the sampling period;
					// a counter at zero fails even when the confirm code was seen
					if (hs_count != 0)
						hs_count--;
					if (hs_count % fchs_pkg::CONFIRM_PERIOD == 0
							&& st == fchs_pkg::ST_CONFIRM) begin
						r.dm_write = 1'b1;
						r.dm_value = fchs_pkg::DM_SHORT;
						hs_phase   = HS_OK_WAIT;
						hs_count   = wait_ok;
					end
					if (hs_count == 0)
						hs_phase = HS_FAILING;
				end
				HS_OK_WAIT: begin
					if (hs_count != 0) begin
						hs_count--;
					end else begin
						r.vin_write = 1'b1;
						r.vin_value = fchs_pkg::VIN_RAISED;
						hs_phase    = HS_VIN_SETTLE;
						hs_count    = wait_settle;
					end
				end
				HS_VIN_SETTLE: begin
					if (hs_count != 0) begin
						hs_count--;
					end else begin
						r.dm_write = 1'b1;
						r.dm_value = fchs_pkg::DM_REQ_HV;
						hs_phase   = HS_REQ_SETTLE;
						hs_count   = wait_settle;
					end
				end
				HS_REQ_SETTLE: begin
					// first reading: at or above threshold passes
					if (hs_count != 0) begin
						hs_count--;
					end else if (mv < thr_mv) begin
						hs_phase = HS_RETRY_SETTLE;
						hs_count = wait_settle;
					end else begin
						r = with_fast_charge(r);
					end
				end
				HS_RETRY_SETTLE: begin
					// retry reading must be strictly above threshold
					if (hs_count != 0)
						hs_count--;
					else if (mv > thr_mv)
						r = with_fast_charge(r);
					else
						hs_phase = HS_FAILING;
				end
				HS_FAILING: begin
					r               = with_fallback(r);
					r.charge_resume = 1'b1;
					r.proceed       = 1'b0;
					hs_outcome      = fchs_pkg::OUT_FAILED;
				end
				default: r.proceed = 1'b1;
			endcase
		end

		r.outcome = hs_outcome;
		r.phase   = hs_phase;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	// values sampled at the edge are the pre-edge ones the DUT also sees
	always @(posedge clk) begin : result_check
		fchs_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with no expected result, expected none, got phase %0d",
					$time, phase);
				err_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("dm_write", 32'(want.dm_write), 32'(dm_write));
				check_field("dm_value", 32'(want.dm_value), 32'(dm_value));
				check_field("vin_write", 32'(want.vin_write), 32'(vin_write));
				check_field("vin_value", 32'(want.vin_value), 32'(vin_value));
				check_field("gpo_set", 32'(want.gpo_set), 32'(gpo_set));
				check_field("charge_start", 32'(want.charge_start), 32'(charge_start));
				check_field("charge_pause", 32'(want.charge_pause), 32'(charge_pause));
				check_field("charge_resume", 32'(want.charge_resume), 32'(charge_resume));
				check_field("fast_charge", 32'(want.fast_charge), 32'(fast_charge));
				check_field("proceed", 32'(want.proceed), 32'(proceed));
				check_field("outcome", 32'(want.outcome), 32'(outcome));
				check_field("phase", 32'(want.phase), 32'(phase));
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, or a long counted hold-off on request
	// ------------------------------------------------------------------
	initial begin : result_sink
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_req = 1'b0;
			end else begin
				out_ready <= !out_gaps_on || ($urandom_range(0, 99) >= 29);
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// called right after a rising edge; returns at the edge that takes the beat
	task automatic send_beat(input logic op, input logic [7:0] st, input logic [9:0] code);
		while (in_gaps_on && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		dm_status <= st;
		vbus_code <= code;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_beat(op, st, code));
	endtask

	// mostly well-formed handshakes with random content, plus some noise
	task automatic send_guided();
		logic       op;
		logic [7:0] st;
		logic [9:0] code;
		int         near;
		op   = OP_TICK;
		st   = 8'($urandom_range(0, 255));
		code = 10'($urandom_range(0, 1023));
		if ($urandom_range(0, 99) < 8) begin
			op = 1'($urandom_range(0, 1));
		end else if (hs_outcome != fchs_pkg::OUT_PENDING && $urandom_range(0, 99) < 40) begin
			op = OP_START;
		end else if ($urandom_range(0, 199) == 0) begin
			op = OP_START;
		end else begin
			case (hs_phase)
				HS_START_WAIT, HS_DISC_WAIT:
					if (hs_count == 0 && $urandom_range(0, 99) < 85)
						st = fchs_pkg::ST_READY;
				HS_CONFIRM:
					if ($urandom_range(0, 99) < 50)
						st = fchs_pkg::ST_CONFIRM;
				HS_REQ_SETTLE, HS_RETRY_SETTLE:
					// land a couple of codes either side of the threshold
					if (hs_count == 0 && $urandom_range(0, 99) < 70) begin
						near = int'(thr_mv) / 25 - 3 + int'($urandom_range(0, 4));
						if (near < 0)
							near = 0;
						if (near > 1023)
							near = 1023;
						code = near[9:0];
					end
				default: ;
			endcase
		end
		send_beat(op, st, code);
	endtask

	task automatic send_guided_run(input int count);
		repeat (count) send_guided();
	endtask

	// sender pauses until every expected result beat is back
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	// only called with the block idle
	task automatic apply_config(input logic [14:0] thr, input logic [7:0] sw,
			input logic [7:0] dw, input logic [7:0] cw, input logic [7:0] ow,
			input logic [7:0] sett);
		wait_drain();
		write_reg(fchs_pkg::REG_VBUS_THRESHOLD, thr);
		write_reg(fchs_pkg::REG_START_WAIT, {7'd0, sw});
		write_reg(fchs_pkg::REG_DISC_WAIT, {7'd0, dw});
		write_reg(fchs_pkg::REG_CONFIRM_WINDOW, {7'd0, cw});
		write_reg(fchs_pkg::REG_OK_WAIT, {7'd0, ow});
		write_reg(fchs_pkg::REG_SETTLE, {7'd0, sett});
		@(posedge clk);
		cfg_we      <= 1'b0;
		thr_mv      = thr;
		wait_start  = sw;
		wait_disc   = dw;
		win_confirm = cw;
		wait_ok     = ow;
		wait_settle = sett;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// ticks straight out of reset run from the idle phase; field extremes
	task automatic test_tick_before_start();
		send_beat(OP_TICK, 8'h00, 10'h000);
		send_beat(OP_TICK, 8'hFF, 10'h3FF);
	endtask

	// short waits; window of 11 so the first decrement lands on a sampling point
	task automatic test_handshake_success();
		apply_config(15'd8300, 8'd0, 8'd0, 8'd11, 8'd1, 8'd0);
		send_beat(OP_START, 8'h00, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd0);
		send_beat(OP_TICK, fchs_pkg::ST_READY, 10'd0);
		send_beat(OP_TICK, fchs_pkg::ST_READY, 10'd0);
		send_beat(OP_TICK, fchs_pkg::ST_CONFIRM, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd0);     // ok wait runs out
		send_beat(OP_TICK, 8'h00, 10'd0);     // input regulation raised
		send_beat(OP_TICK, 8'h00, 10'd0);     // higher voltage requested
		send_beat(OP_TICK, 8'h00, 10'd331);   // exactly at threshold passes
		send_beat(OP_TICK, 8'h00, 10'd0);     // decided: proceed stays high
	endtask

	// first reading low, retry exactly at threshold fails, then fallback
	task automatic test_retry_then_fail();
		send_beat(OP_START, 8'h00, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd0);
		send_beat(OP_TICK, fchs_pkg::ST_READY, 10'd0);
		send_beat(OP_TICK, fchs_pkg::ST_READY, 10'd0);
		send_beat(OP_TICK, fchs_pkg::ST_CONFIRM, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd330);
		send_beat(OP_TICK, 8'h00, 10'd331);
		send_beat(OP_TICK, 8'h00, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd0);
	endtask

	// wrong line status after shorting goes straight to failing
	task automatic test_bad_status();
		send_beat(OP_START, 8'h00, 10'd0);
		send_beat(OP_TICK, 8'h00, 10'd0);
		send_beat(OP_TICK, 8'hFF, 10'h3FF);
		send_beat(OP_TICK, 8'h00, 10'd0);
	endtask

	task automatic test_random_sequences();
		// default register values, written back explicitly
		apply_config(fchs_pkg::RST_VBUS_THRESHOLD, fchs_pkg::RST_START_WAIT,
			fchs_pkg::RST_DISC_WAIT, fchs_pkg::RST_CONFIRM_WINDOW,
			fchs_pkg::RST_OK_WAIT, fchs_pkg::RST_SETTLE);
		send_guided_run(250);
		// all low: zero waits, any voltage would pass, but a zero confirm window always fails
		apply_config(15'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_guided_run(250);
		// all high: longest waits, retry can never pass
		apply_config(15'd25600, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		send_guided_run(250);
		repeat (3) begin
			apply_config(15'($urandom_range(0, 25600)), 8'($urandom_range(0, 15)),
				8'($urandom_range(0, 15)), 8'($urandom_range(0, 40)),
				8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
			send_guided_run(200);
		end
		// back-to-back stretch, no gaps on either side
		wait_drain();
		in_gaps_on  = 1'b0;
		out_gaps_on = 1'b0;
		send_guided_run(120);
		in_gaps_on  = 1'b1;
		out_gaps_on = 1'b1;
	endtask

	// long result hold-off while beats keep coming: input must stall
	task automatic test_output_stall();
		apply_config(15'd8300, 8'd2, 8'd1, 8'd21, 8'd1, 8'd1);
		stall_req = 1'b1;
		send_guided_run(60);
	endtask

	initial begin : main_seq
		err_count   = 0;
		in_gaps_on  = 1'b1;
		out_gaps_on = 1'b1;
		stall_req   = 1'b0;
		hs_phase    = HS_IDLE;
		hs_count    = '0;
		hs_outcome  = fchs_pkg::OUT_PENDING;
		thr_mv      = fchs_pkg::RST_VBUS_THRESHOLD;
		wait_start  = fchs_pkg::RST_START_WAIT;
		wait_disc   = fchs_pkg::RST_DISC_WAIT;
		win_confirm = fchs_pkg::RST_CONFIRM_WINDOW;
		wait_ok     = fchs_pkg::RST_OK_WAIT;
		wait_settle = fchs_pkg::RST_SETTLE;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= fchs_pkg::REG_VBUS_THRESHOLD;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		operation <= OP_START;
		dm_status <= '0;
		vbus_code <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tick_before_start();
		test_handshake_success();
		test_retry_then_fail();
		test_bad_status();
		test_random_sequences();
		test_output_stall();

		wait_drain();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fchs_pkg.sv
rtl/fast_charge_handshake_fsm_unit.sv
rtl/fchs_checker.sv
bench/fast_charge_handshake_fsm_unit_tb.sv
